FILE: hdl/prefix_sum_bucket_search_defines.svh
// Assertion helpers used by the block's datapath.
`ifndef PREFIX_SUM_BUCKET_SEARCH_DEFINES_SVH
`define PREFIX_SUM_BUCKET_SEARCH_DEFINES_SVH

// Implication checked in the same cycle.
`define PSBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psbs: implication check failed");

// Condition that must hold in every cycle out of reset.
`define PSBS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("psbs: invariant check failed");

`endif

FILE: hdl/psbs_pkg.sv
package psbs_pkg;

  localparam int COUNT_W   = 32;
  localparam int TARGET_W  = 48;
  localparam int IN_DATA_W = 80;
  localparam int IDX_W     = 11;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue_rd;
    logic cmp;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic query;
    logic miss;
    logic search_last;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/prefix_sum_bucket_search.sv
// Running-total table with lower-bound search. Clear and append transfers
// complete in the cycle they are accepted. A query walks the stored totals
// with a binary search over the single read port of the totals memory: each
// step reads an entry in the READ state and compares it in the CMP state,
// and the output register is loaded in the RESULT state once it is free; a
// query that misses (empty table or target past the grand total) skips the
// search and goes straight to RESULT. The result sits in an output register,
// so the next item is accepted while it waits. The totals memory needs no
// initialisation: only entries already appended are ever read. Action code 3
// is accepted and dropped.
module prefix_sum_bucket_search #(
  parameter int MAX_BUCKETS = 1024,
  parameter int SUM_WIDTH   = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [psbs_pkg::IN_DATA_W-1:0]  in_tdata,   // count_value[31:0], target[79:32]
  input  logic [1:0]                      in_tuser,   // action[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [psbs_pkg::OUT_DATA_W-1:0] out_tdata,  // bucket_index[10:0], zeros above
  output logic                            out_tuser   // found
);

  psbs_pkg::cmd_t    cmd;
  psbs_pkg::status_t status;

  psbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  psbs_datapath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

FILE: hdl/psbs_ctrl.sv
module psbs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  psbs_pkg::status_t  status,
  output psbs_pkg::cmd_t     cmd
);

  psbs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    unique case (state_r)
      psbs_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && status.query) begin
          state_nxt = status.miss ? psbs_pkg::ST_RESULT : psbs_pkg::ST_READ;
        end
      end
      psbs_pkg::ST_READ: begin
        cmd.issue_rd = 1'b1;
        state_nxt    = psbs_pkg::ST_CMP;
      end
      psbs_pkg::ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = status.search_last ? psbs_pkg::ST_RESULT : psbs_pkg::ST_READ;
      end
      psbs_pkg::ST_RESULT: begin
        // hold the answer until the output register can take it
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = psbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/psbs_datapath.sv
`include "prefix_sum_bucket_search_defines.svh"

module psbs_datapath #(
  parameter int MAX_BUCKETS = 1024,
  parameter int SUM_WIDTH   = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [psbs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [psbs_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser,
  input  psbs_pkg::cmd_t                     cmd,
  output psbs_pkg::status_t                  status
);

  localparam int IW  = $clog2(MAX_BUCKETS + 1);
  localparam int AW  = $clog2(MAX_BUCKETS);
  localparam int SW  = ((SUM_WIDTH > psbs_pkg::COUNT_W) ? SUM_WIDTH : psbs_pkg::COUNT_W) + 1;
  localparam int CW  = (SUM_WIDTH > psbs_pkg::TARGET_W) ? SUM_WIDTH : psbs_pkg::TARGET_W;
  localparam int XW  = (IW + 1 > psbs_pkg::IDX_W) ? IW + 1 : psbs_pkg::IDX_W;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  psbs_pkg::act_t                 action;
  logic [psbs_pkg::COUNT_W-1:0]   count_value;
  logic [psbs_pkg::TARGET_W-1:0]  target;

  logic [SUM_WIDTH-1:0]           mem [MAX_BUCKETS];
  logic [SUM_WIDTH-1:0]           rd_data_r;

  logic [IW-1:0]                  entry_count_r;
  logic [SUM_WIDTH-1:0]           grand_total_r;
  logic [psbs_pkg::TARGET_W-1:0]  target_r;
  logic [IW-1:0]                  lo_r, hi_r, lo_nxt, hi_nxt;
  logic [AW-1:0]                  mid_r;
  logic                           found_r;
  logic                           out_valid_r;
  logic [psbs_pkg::IDX_W-1:0]     out_index_r;
  logic                           out_found_r;

  logic [SW-1:0]                  sum_wide;
  logic [SUM_WIDTH-1:0]           sum_sat;
  logic                           full;
  logic                           do_append;
  logic [IW-1:0]                  mid_w;
  logic [XW-1:0]                  idx_wide;

  assign action      = psbs_pkg::act_t'(in_tuser);
  assign count_value = in_tdata[psbs_pkg::COUNT_W-1:0];
  assign target      = in_tdata[psbs_pkg::IN_DATA_W-1:psbs_pkg::COUNT_W];

  // saturate the running total at the top of its range
  assign sum_wide  = SW'(grand_total_r) + SW'(count_value);
  assign sum_sat   = (sum_wide > SW'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_WIDTH-1:0];
  assign full      = (entry_count_r == IW'(MAX_BUCKETS));
  assign do_append = cmd.accept && (action == psbs_pkg::ACT_APPEND) && !full;

  assign mid_w    = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_wide = XW'(lo_r) + XW'(1);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (CW'(rd_data_r) < CW'(target_r)) begin
      lo_nxt = IW'(mid_r) + IW'(1);
    end else begin
      hi_nxt = IW'(mid_r);
    end
  end

  assign status.query       = (action == psbs_pkg::ACT_QUERY);
  assign status.miss        = (entry_count_r == '0) || (CW'(target) > CW'(grand_total_r));
  assign status.search_last = (lo_nxt >= hi_nxt);
  assign status.out_free    = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      grand_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        unique case (action)
          psbs_pkg::ACT_CLEAR: begin
            entry_count_r <= '0;
            grand_total_r <= '0;
          end
          psbs_pkg::ACT_APPEND: begin
            if (!full) begin
              entry_count_r <= entry_count_r + IW'(1);
              grand_total_r <= sum_sat;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.query) begin
      target_r <= target;
      lo_r     <= '0;
      hi_r     <= entry_count_r;
      found_r  <= !status.miss;
    end
    if (cmd.cmp) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (cmd.issue_rd) begin
      mid_r <= mid_w[AW-1:0];
    end
    if (cmd.load_out) begin
      out_index_r <= found_r ? idx_wide[psbs_pkg::IDX_W-1:0] : '0;
      out_found_r <= found_r;
    end
  end

  // single write port for appends, single registered read port for the search
  always_ff @(posedge clk) begin
    if (do_append) begin
      mem[entry_count_r[AW-1:0]] <= sum_sat;
    end
    if (cmd.issue_rd) begin
      rd_data_r <= mem[mid_w[AW-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(psbs_pkg::OUT_DATA_W - psbs_pkg::IDX_W){1'b0}}, out_index_r};
  assign out_tuser  = out_found_r;

  `PSBS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, entry_count_r <= IW'(MAX_BUCKETS))
  `PSBS_ASSERT_IMP(a_read_in_window, clk, rst_n, cmd.issue_rd, (lo_r < hi_r) && (mid_w < hi_r))
  `PSBS_ASSERT_IMP(a_cmp_mid_valid, clk, rst_n, cmd.cmp,
                   (IW'(mid_r) >= lo_r) && (IW'(mid_r) < hi_r) && (hi_r <= entry_count_r))

endmodule
